[sv/vtm_pkg.sv]
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types and constants for the 4x4 vertex transform engine.
// ----------------------------------------------------------------------------
package vtm_pkg;

  // value format, signed fixed point
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // width of every value field on the ports
  localparam int DATA_W = 32;

  // matrix and vector size
  localparam int DIM     = 4;
  localparam int ELEMS   = DIM * DIM;
  localparam int ELEM_IW = $clog2(ELEMS);

  // product and four-term sum widths
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int SUM_W  = PROD_W + 2;

  // value range and the reset diagonal value
  localparam longint VAL_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam longint VAL_MIN = -VAL_MAX - 64'sd1;
  localparam longint ONE_RAW = 64'sd1 <<< FRAC_BITS;
  localparam longint ONE_VAL = (ONE_RAW > VAL_MAX) ? VAL_MAX : ONE_RAW;

  // result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // operation codes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  // one lane's finished component
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } lane_out_t;

  // one queued result item
  typedef struct packed {
    logic [DIM*DATA_W-1:0] data;
    logic                  sat;
  } result_t;

endpackage

[sv/vertex_transform_mat4_top.sv]
// ----------------------------------------------------------------------------
// vertex_transform_mat4_top
// 4x4 matrix times 4-vector engine in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser is the operation. A write item (0) stores
// element_value at matrix position element_index (row + 4 * column) and
// gives no result. A transform item (1) carries vector x, y, z, w and gives
// one result item on m_*: four saturated components in tdata and the
// saturation flag in tuser.
// A transform passes the product and sum registers, then is shifted and
// saturated into the result queue, from which m_tvalid shows it.
// Throughput: one item per cycle while s_tready is high; four lanes of
// four 32x32 multipliers work on all rows at once. A write is seen by a
// transform accepted in the very next cycle.
// s_tready depends only on registered credit state: up to four transforms
// may be in flight or queued. When the receiver stalls, results collect
// in the four-entry queue and s_tready drops once it is spoken for;
// writes then wait as well.
// Reset (rst, synchronous) loads the identity matrix and empties the
// pipeline and the result queue.
// ----------------------------------------------------------------------------
module vertex_transform_mat4_top import vtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [167:0]          s_tdata,  // element_index, element_value, vector_x,
                                          // vector_y, vector_z, vector_w, zero pad
  input  logic                  s_tuser,  // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DIM*DATA_W-1:0] m_tdata,  // result_x, result_y, result_z, result_w
  output logic                  m_tuser   // saturated
);

  localparam int VALUE_LO = ELEM_IW;
  localparam int VEC_LO   = ELEM_IW + DATA_W;

  val_t              matrix [ELEMS];
  val_t              vec [DIM];
  val_t              row [DIM][DIM];
  lane_out_t         lanes [DIM];
  logic [ELEM_IW-1:0] elem_idx;
  val_t              elem_val;
  logic              accept;
  logic              take;
  logic              write_en;
  logic              valid_a;
  logic              valid_b;
  logic              room;

  // input decode, low value bits read as two's complement
  assign accept   = s_tvalid && s_tready;
  assign take     = accept && (s_tuser == OP_XFORM);
  assign write_en = accept && (s_tuser == OP_WRITE);
  assign elem_idx = s_tdata[ELEM_IW-1:0];
  assign elem_val = s_tdata[VALUE_LO +: VALUE_BITS];
  assign s_tready = room;

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      vec[j] = s_tdata[VEC_LO + j*DATA_W +: VALUE_BITS];
    end
  end

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ELEMS; k++) begin
        matrix[k] <= ((k % (DIM + 1)) == 0) ? VALUE_BITS'(ONE_VAL) : '0;
      end
    end else if (write_en) begin
      matrix[elem_idx] <= elem_val;
    end
  end

  // one lane per output row
  for (genvar i = 0; i < DIM; i++) begin : g_lane
    for (genvar j = 0; j < DIM; j++) begin : g_col
      assign row[i][j] = matrix[i + DIM*j];
    end
    vtm_lane u_lane (
      .clk    (clk),
      .vec    (vec),
      .row    (row[i]),
      .result (lanes[i])
    );
  end

  // pipeline occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      valid_a <= take;
      valid_b <= valid_a;
    end
  end

  // result join and output queue
  vtm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .push     (valid_b),
    .lanes    (lanes),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[sv/vtm_lane.sv]
// ----------------------------------------------------------------------------
// vtm_lane
// One output row: four multipliers, a registered sum, then shift and
// saturate to the value range.
// ----------------------------------------------------------------------------
module vtm_lane import vtm_pkg::*; (
  input  logic      clk,
  input  val_t      vec [DIM],
  input  val_t      row [DIM],
  output lane_out_t result
);

  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  shifted;
  val_t                     clipped;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(VAL_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(VAL_MIN);

  // product stage
  always_ff @(posedge clk) begin
    for (int j = 0; j < DIM; j++) begin
      prod[j] <= PROD_W'(vec[j]) * PROD_W'(row[j]);
    end
  end

  // four-term sum, exact
  always_comb begin
    sum_next = '0;
    for (int j = 0; j < DIM; j++) begin
      sum_next = sum_next + SUM_W'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

  // drop fraction bits and clip
  always_comb begin
    shifted = sum >>> FRAC_BITS;
    result.sat = 1'b0;
    if (shifted > SUM_MAX) begin
      clipped    = VALUE_BITS'(VAL_MAX);
      result.sat = 1'b1;
    end else if (shifted < SUM_MIN) begin
      clipped    = VALUE_BITS'(VAL_MIN);
      result.sat = 1'b1;
    end else begin
      clipped = shifted[VALUE_BITS-1:0];
    end
    result.value = DATA_W'(clipped);
  end

endmodule

[sv/vtm_merge.sv]
// ----------------------------------------------------------------------------
// vtm_merge
// Joins the four lane results into one item, queues it for the output
// channel and keeps the credit count that bounds items in flight.
// ----------------------------------------------------------------------------
module vtm_merge import vtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic                  push,
  input  lane_out_t             lanes [DIM],
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DIM*DATA_W-1:0] m_tdata,  // result_x, result_y, result_z, result_w
  output logic                  m_tuser   // saturated
);

  result_t          fifo [FIFO_DEPTH];
  result_t          entry;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fifo_cnt;
  logic [CNT_W-1:0] fifo_cnt_next;
  logic [CNT_W-1:0] credit;
  logic [CNT_W-1:0] credit_next;
  logic             pop;

  // combine lanes, flag is set if any lane clipped
  always_comb begin
    entry.sat = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      entry.data[i*DATA_W +: DATA_W] = lanes[i].value;
      entry.sat = entry.sat | lanes[i].sat;
    end
  end

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = fifo[rd_ptr].data;
  assign m_tuser  = fifo[rd_ptr].sat;
  assign room     = (credit < CNT_W'(FIFO_DEPTH));

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

  // counts
  always_comb begin
    fifo_cnt_next = fifo_cnt + CNT_W'(push) - CNT_W'(pop);
    credit_next   = credit + CNT_W'(take) - CNT_W'(pop);
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      credit   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt_next;
      credit   <= credit_next;
    end
  end

  // a push never lands on a full queue
  assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_cnt < CNT_W'(FIFO_DEPTH)) || pop)
    else $error("vtm_merge: result queue overflow");

  // queued items are always covered by credits
  assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= credit)
    else $error("vtm_merge: queue holds more items than credits");

  // credit never passes the queue depth
  assert property (@(posedge clk) disable iff (rst)
    credit <= CNT_W'(FIFO_DEPTH))
    else $error("vtm_merge: credit count out of range");

endmodule

[dv/vertex_transform_mat4_top_test.sv]
// ----------------------------------------------------------------------------
// vertex_transform_mat4_top_test
// Stream-level test of the 4x4 fixed-point vertex transform engine. A short
// table of directed items covers identity, saturation in both directions,
// rounding of negative products and ignored fields. It is followed by a mixed
// run of random element writes and vector transforms. Every result is checked
// against its typed-in expectation or an in-bench model of the matrix store
// and the multiply-accumulate, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module vertex_transform_mat4_top_test import vtm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  S_W          = 168;
  localparam int  VAL_LSB      = ELEM_IW;
  localparam int  VEC_LSB      = ELEM_IW + DATA_W;
  localparam int  HALF_PERIOD  = 2;
  localparam int  RESET_CYCLES = 6;
  localparam int  RANDOM_ITEMS = 1830;
  localparam int  SHOWN_MAX    = 10;
  localparam int  STALL_LIMIT  = 500;
  localparam int  DRAIN_TAIL   = 8;

  // handy Q16.16 constants for the directed table
  localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;
  localparam logic [DATA_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;

  typedef logic [DIM-1:0][DATA_W-1:0] vec4_t;

  // one result item as it appears on {m_tdata, m_tuser}
  typedef struct packed {
    vec4_t comp;
    logic  sat;
  } vertex_out_t;

  // one row of the directed table
  typedef struct {
    logic              op;
    logic [ELEM_IW-1:0] idx;
    logic [DATA_W-1:0] value;
    vec4_t             vec;
    logic              known;
    vertex_out_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DIM*DATA_W-1:0] m_tdata;
  logic m_tuser;

  // typed-in expectation travelling with the item being offered
  logic        typed_known = 1'b0;
  vertex_out_t typed_want  = '0;

  val_t        matrix [ELEMS];
  vertex_out_t expected_vertices [$];
  vertex_out_t got_vertex;
  vertex_out_t want_vertex;
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  string       comp_names [DIM] = '{"result_x", "result_y", "result_z", "result_w"};

  vertex_transform_mat4_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // matrix times vector, exact sum, arithmetic shift, saturate
  function automatic vertex_out_t transform_vertex(input vec4_t v);
    vertex_out_t o;
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
    logic signed [DATA_W-1:0] ext;
    val_t vj;
    val_t r;
    o.sat = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int j = 0; j < DIM; j++) begin
        vj  = v[j][VALUE_BITS-1:0];
        a   = SUM_W'(vj);
        b   = SUM_W'(matrix[i + DIM * j]);
        acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > VAL_MAX) begin
        acc   = SUM_W'(VAL_MAX);
        o.sat = 1'b1;
      end else if (acc < VAL_MIN) begin
        acc   = SUM_W'(VAL_MIN);
        o.sat = 1'b1;
      end
      r         = acc[VALUE_BITS-1:0];
      ext       = DATA_W'(r);
      o.comp[i] = ext;
    end
    return o;
  endfunction

  // random Q16.16 value: raw bits, small, medium or a corner value
  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2: rand_q = $urandom;
      3, 4, 5, 6: rand_q = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      7: rand_q = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: rand_q = Q_MAX;
          1: rand_q = Q_MIN;
          2: rand_q = '0;
          3: rand_q = Q_NEG1;
          4: rand_q = 32'd1;
          default: rand_q = Q_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic stim_row_t row(input logic op, input logic [ELEM_IW-1:0] idx,
                                    input logic [DATA_W-1:0] value,
                                    input logic [DATA_W-1:0] x, y, z, w,
                                    input logic known,
                                    input logic [DATA_W-1:0] ex, ey, ez, ew,
                                    input logic esat);
    stim_row_t r;
    r.op    = op;
    r.idx   = idx;
    r.value = value;
    r.vec   = {w, z, y, x};
    r.known = known;
    r.want  = '{comp: {ew, ez, ey, ex}, sat: esat};
    return r;
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= SHOWN_MAX) $display("%s", msg);
  endtask

  // offer one item after a random gap (none while quiet) and hold it until accepted
  task automatic send_item(input logic op, input logic [ELEM_IW-1:0] idx,
                           input logic [DATA_W-1:0] value, input vec4_t vec,
                           input logic known, input vertex_out_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= op;
    s_tdata     <= {{(S_W - VEC_LSB - DIM * DATA_W){1'b0}}, vec, value, idx};
    typed_known <= known;
    typed_want  <= want;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // result side: random stalls, none while quiet
  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // check results, track the matrix, predict, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_vertex = vertex_out_t'({m_tdata, m_tuser});
        if (expected_vertices.size() == 0) begin
          flag($sformatf("unexpected result %h sat %b", got_vertex.comp, got_vertex.sat));
        end else begin
          want_vertex = expected_vertices.pop_front();
          for (int i = 0; i < DIM; i++) begin
            if (got_vertex.comp[i] !== want_vertex.comp[i])
              flag($sformatf("%s expected %h got %h", comp_names[i],
                             want_vertex.comp[i], got_vertex.comp[i]));
          end
          if (got_vertex.sat !== want_vertex.sat)
            flag($sformatf("saturated expected %b got %b", want_vertex.sat, got_vertex.sat));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_WRITE) begin
          matrix[s_tdata[ELEM_IW-1:0]] = s_tdata[VAL_LSB +: VALUE_BITS];
        end else begin
          want_vertex = transform_vertex(s_tdata[VEC_LSB +: DIM * DATA_W]);
          if (typed_known) want_vertex = typed_want;
          expected_vertices.push_back(want_vertex);
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[vertex_transform_mat4_top] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   tab [$];
    vertex_out_t blank;
    vec4_t       v;
    logic        op;
    blank = '0;

    // identity after reset
    for (int k = 0; k < ELEMS; k++) matrix[k] = '0;
    for (int k = 0; k < DIM; k++) matrix[k * (DIM + 1)] = ONE_VAL[VALUE_BITS-1:0];

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity passes vectors through unchanged
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_ONE, 32'h0002_0000, 32'hFFFD_0000,
                      32'h0004_0000, 1'b1, Q_ONE, 32'h0002_0000, 32'hFFFD_0000,
                      32'h0004_0000, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MAX, Q_MIN, '0, Q_NEG1,
                      1'b1, Q_MAX, Q_MIN, '0, Q_NEG1, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, 32'd1, Q_NEG1, Q_HALF, 32'hFFFF_8000,
                      1'b1, 32'd1, Q_NEG1, Q_HALF, 32'hFFFF_8000, 1'b0));
    // largest element: clip high and low; vector fields of a write ignored
    tab.push_back(row(OP_WRITE, 4'd0, Q_MAX, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MAX, '0, '0, '0,
                      1'b1, Q_MAX, '0, '0, '0, 1'b1));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MIN, '0, '0, '0,
                      1'b1, Q_MIN, '0, '0, '0, 1'b1));
    // most negative element times most negative component
    tab.push_back(row(OP_WRITE, 4'd0, Q_MIN, '0, '0, '0, '0,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MIN, '0, '0, '0,
                      1'b1, Q_MAX, '0, '0, '0, 1'b1));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MAX, Q_MAX, Q_MIN, Q_MIN,
                      1'b0, '0, '0, '0, '0, 1'b0));
    // shift rounds toward minus infinity
    tab.push_back(row(OP_WRITE, 4'd0, Q_ONE, '0, '0, '0, '0,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_WRITE, 4'd15, Q_HALF, '0, '0, '0, '0,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, '0, '0, '0, Q_NEG1,
                      1'b1, '0, '0, '0, Q_NEG1, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, '0, '0, '0, 32'd1,
                      1'b1, '0, '0, '0, '0, 1'b0));
    // off-diagonal elements; index and value fields of a transform ignored
    tab.push_back(row(OP_WRITE, 4'd4, 32'h0002_0000, 32'h1234_5678, Q_MIN, Q_MAX, 32'd7,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd15, 32'h5A5A_5A5A, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_WRITE, 4'd12, Q_MIN, '0, '0, '0, '0,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_WRITE, 4'd3, Q_MAX, '0, '0, '0, '0,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                      1'b0, '0, '0, '0, '0, 1'b0));
    tab.push_back(row(OP_XFORM, 4'd0, '0, 32'h0003_8000, 32'hFFFE_0000, Q_HALF, Q_ONE,
                      1'b0, '0, '0, '0, '0, 1'b0));

    foreach (tab[k])
      send_item(tab[k].op, tab[k].idx, tab[k].value, tab[k].vec, tab[k].known, tab[k].want);

    // random mix of element writes and transforms
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      // hold off until the block has delivered everything
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      op = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_XFORM;
      for (int j = 0; j < DIM; j++) v[j] = rand_q();
      send_item(op, ELEM_IW'($urandom_range(0, ELEMS - 1)), rand_q(), v, 1'b0, blank);
    end

    // drain and let the pipeline settle
    s_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (expected_vertices.size() != 0)
      flag($sformatf("%0d results never arrived", expected_vertices.size()));

    if (errors == 0) begin
      $display("[vertex_transform_mat4_top] OK");
    end else begin
      $display("[vertex_transform_mat4_top] ERROR");
    end
    $finish;
  end

endmodule
